FILE: sv/dertlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder package
// Shared command codes, octet constants and the octet-burst descriptor.
// ----------------------------------------------------------------------------
package dertlv_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_VALUE  = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_RAW    = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    localparam int MAX_OCTETS = 10;
    localparam int CNT_W      = $clog2(MAX_OCTETS + 1);
    localparam int IDX_W      = $clog2(MAX_OCTETS);

    localparam logic [4:0] TAG_LONG      = 5'h1F;
    localparam logic [4:0] TAG_SHORT_MAX = 5'd30;
    localparam logic [7:0] LEN_SHORT_MAX = 8'h7F;
    localparam logic [7:0] LEN_LONG      = 8'h80;
    localparam logic [7:0] DIGIT_MORE    = 8'h80;

    // One item's octets in transmission order, element 0 first
    typedef struct packed {
        logic [MAX_OCTETS-1:0][7:0] octets;
        logic [CNT_W-1:0]           count;
    } t_desc;

    // Queue handshake toward the serializer
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_qout;

endpackage

FILE: sv/dertlv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder channel interfaces
// Command channel and octet channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dertlv_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  class_form;
    logic [27:0] tag;
    logic [31:0] content_length;
    logic [2:0]  value_size;
    logic [31:0] value;

    modport source (output valid, cmd, class_form, tag, content_length, value_size, value,
                    input ready);
    modport sink   (input valid, cmd, class_form, tag, content_length, value_size, value,
                    output ready);
endinterface

interface dertlv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: sv/dertlv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder front end
// Accepts command items and builds the octet burst descriptor for each.
// ----------------------------------------------------------------------------
module dertlv_front
    import dertlv_pkg::*;
(
    dertlv_cmd_if.sink i_cmd,
    input  logic       i_q_full,
    output logic       o_push,
    output t_desc      o_desc
);

    always_comb begin
        logic [MAX_OCTETS-1:0][7:0] b;
        logic [IDX_W:0]  pos;
        logic [7:0]      id;
        logic [2:0]      ndig;
        logic [2:0]      nlen;
        logic [2:0]      nval;
        logic [31:0]     len;

        b    = '0;
        pos  = '0;
        len  = i_cmd.content_length;
        id   = {i_cmd.class_form, 5'd0};

        if (i_cmd.tag[27:21] != 7'd0)      ndig = 3'd4;
        else if (i_cmd.tag[20:14] != 7'd0) ndig = 3'd3;
        else if (i_cmd.tag[13:7] != 7'd0)  ndig = 3'd2;
        else                               ndig = 3'd1;

        if (len[31:24] != 8'd0)      nlen = 3'd4;
        else if (len[23:16] != 8'd0) nlen = 3'd3;
        else if (len[15:8] != 8'd0)  nlen = 3'd2;
        else                         nlen = 3'd1;

        if (i_cmd.value_size == 3'd1)      nval = 3'd1;
        else if (i_cmd.value_size == 3'd2) nval = 3'd2;
        else                               nval = 3'd4;

        if (t_cmd'(i_cmd.cmd) == CMD_RAW) begin
            b[0] = i_cmd.value[7:0];
            pos  = (IDX_W+1)'(1);
        end else begin
            // identifier, short or long tag form
            if (i_cmd.tag <= 28'(TAG_SHORT_MAX)) begin
                b[pos[IDX_W-1:0]] = id | {3'd0, i_cmd.tag[4:0]};
                pos = pos + 1'b1;
            end else begin
                b[pos[IDX_W-1:0]] = id | {3'd0, TAG_LONG};
                pos = pos + 1'b1;
                for (int d = 3; d >= 0; d--) begin
                    if (3'(d) < ndig) begin
                        b[pos[IDX_W-1:0]] = {1'b0, 7'(i_cmd.tag >> (7 * d))}
                                            | ((d != 0) ? DIGIT_MORE : 8'd0);
                        pos = pos + 1'b1;
                    end
                end
            end

            if (t_cmd'(i_cmd.cmd) == CMD_VALUE) begin
                b[pos[IDX_W-1:0]] = {5'd0, nval};
                pos = pos + 1'b1;
                for (int d = 3; d >= 0; d--) begin
                    if (3'(d) < nval) begin
                        b[pos[IDX_W-1:0]] = 8'(i_cmd.value >> (8 * d));
                        pos = pos + 1'b1;
                    end
                end
            end else begin
                if (len <= 32'(LEN_SHORT_MAX)) begin
                    b[pos[IDX_W-1:0]] = len[7:0];
                    pos = pos + 1'b1;
                end else begin
                    b[pos[IDX_W-1:0]] = LEN_LONG | {5'd0, nlen};
                    pos = pos + 1'b1;
                    for (int d = 3; d >= 0; d--) begin
                        if (3'(d) < nlen) begin
                            b[pos[IDX_W-1:0]] = 8'(len >> (8 * d));
                            pos = pos + 1'b1;
                        end
                    end
                end
            end
        end

        o_desc.octets = b;
        o_desc.count  = CNT_W'(pos);
    end

    assign i_cmd.ready = !i_q_full;
    // the unused command is taken and produces nothing
    assign o_push = i_cmd.valid && !i_q_full && (t_cmd'(i_cmd.cmd) != CMD_UNUSED);

endmodule

FILE: sv/dertlv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder descriptor queue
// Two-entry FIFO between front end and serializer.
// ----------------------------------------------------------------------------
module dertlv_queue
    import dertlv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output t_qout o_q
);

    t_desc      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr ^ i_push;
        n_rptr = r_rptr ^ i_pop;
        n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.desc  = r_mem[r_rptr];

endmodule

FILE: sv/dertlv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder serializer
// Loads one descriptor and sends its octets one per cycle while o_byte.ready is high.
// ----------------------------------------------------------------------------
module dertlv_back
    import dertlv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_qout           i_q,
    output logic            o_pop,
    dertlv_byte_if.source   o_byte
);

    logic [MAX_OCTETS-1:0][7:0] r_octets, n_octets;
    logic [CNT_W-1:0]           r_left,   n_left;
    logic                       fire;
    logic                       load;

    always_comb begin
        fire = o_byte.valid && o_byte.ready;
        // take a new burst when empty or when the final octet leaves
        load = (r_left == '0) || (fire && (r_left == CNT_W'(1)));
        o_pop    = load && i_q.valid;
        n_octets = r_octets;
        n_left   = r_left;
        if (o_pop) begin
            n_octets = i_q.desc.octets;
            n_left   = i_q.desc.count;
        end else if (fire) begin
            n_octets = {8'd0, r_octets[MAX_OCTETS-1:1]};
            n_left   = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_octets <= n_octets;
    end

    assign o_byte.valid    = (r_left != '0);
    assign o_byte.out_byte = r_octets[0];
    assign o_byte.last     = (r_left == CNT_W'(1));

endmodule

FILE: sv/der_tlv_header_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV header encoder
// Turns command items into ASN.1 DER octet bursts with a last marker.
// ----------------------------------------------------------------------------
// Each accepted command item becomes a burst of 1 to 10 DER octets on o_byte,
// the final one flagged by last. A value command sends identifier, length
// and a 1, 2 or 4 byte big-endian primitive (sizes other than 1 and 2 give
// 4 bytes); a header command sends identifier and length only; a raw command
// sends the low byte of value. The unused command code is accepted and sends
// nothing. Tags above 30 use the long form with up to four base-128 digits.
// Rate: the serializer sends one octet per cycle while o_byte.ready is high,
// and that serializer is the limit. A two-entry descriptor queue lets the
// front end keep accepting items while a burst is still draining or stalled,
// and bursts follow each other with no gap. From acceptance, an item passes
// the queue entry and the serializer register before its first octet shows.
// No configuration; reset only clears queue and serializer control.
// ----------------------------------------------------------------------------
module der_tlv_header_encoder_top
    import dertlv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dertlv_cmd_if.sink    i_cmd,
    dertlv_byte_if.source o_byte
);

    // front end -> queue
    logic  push;
    logic  q_full;
    t_desc desc;

    // queue -> serializer
    t_qout qout;
    logic  pop;

    // classify and build the octet burst of each command
    dertlv_front u_front (
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (desc)
    );

    // decouples intake from octet output
    dertlv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_q     (qout)
    );

    // one octet per cycle, while the output is ready, out of a registered shift line
    dertlv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (qout),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

FILE: sv/dertlv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER TLV encoder port checker
// Port-level assertions on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dertlv_checker
    import dertlv_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // items accepted that still owe octets
    logic [2:0] r_open, n_open;
    logic       in_fire;
    logic       end_fire;

    always_comb begin
        in_fire  = i_in_valid && i_in_ready && (t_cmd'(i_in_cmd) != CMD_UNUSED);
        end_fire = i_out_valid && i_out_ready && i_out_last;
        n_open   = r_open + {2'd0, in_fire} - {2'd0, end_fire};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 3'd0;
        end else begin
            r_open <= n_open;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("octet dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("octet changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_open != 3'd0)
        else $error("octet without an open item");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == 3'd0 |-> i_in_ready)
        else $error("not ready while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind der_tlv_header_encoder_top dertlv_checker u_dertlv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_cmd    (i_cmd.cmd),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.out_byte),
    .i_out_last  (o_byte.last)
);
